### src/rau_pkg.sv
// Package of the rational arithmetic unit: opcodes, status codes,
// transaction payload types and the sequencer state type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rau_pkg;

    localparam int DEFAULT_WIDTH = 64;

    localparam logic [3:0] OP_ADD  = 4'd0;
    localparam logic [3:0] OP_SUB  = 4'd1;
    localparam logic [3:0] OP_MUL  = 4'd2;
    localparam logic [3:0] OP_DIV  = 4'd3;
    localparam logic [3:0] OP_IDIV = 4'd4;
    localparam logic [3:0] OP_POW  = 4'd5;
    localparam logic [3:0] OP_NEG  = 4'd6;
    localparam logic [3:0] OP_ABS  = 4'd7;
    localparam logic [3:0] OP_EQ   = 4'd8;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_INVALID   = 2'd1;
    localparam logic [1:0] ST_IDIV_ZERO = 2'd2;

    typedef struct packed {
        logic [3:0]         kind;
        logic signed [63:0] a_num;
        logic [62:0]        a_den;
        logic signed [63:0] b_num;
        logic [62:0]        b_den;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] res_num;
        logic [62:0]        res_den;
        logic [1:0]         status;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_MUL_GO,
        S_MUL_WAIT,
        S_COMBINE,
        S_IDIV,
        S_IDIV_WAIT,
        S_POW,
        S_PMUL_WAIT,
        S_NORM,
        S_GCD_WAIT,
        S_DIVN_WAIT,
        S_DIVD_WAIT,
        S_FIN,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

### src/rau_in_if.sv
// Input channel of the rational arithmetic unit: valid, ready and payload.
// Depends on rau_pkg for the payload type.
`timescale 1ns / 1ps
`default_nettype none

interface rau_in_if;
    logic              valid;
    logic              ready;
    rau_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### src/rau_out_if.sv
// Result channel of the rational arithmetic unit: valid, ready and payload.
// Depends on rau_pkg for the payload type.
`timescale 1ns / 1ps
`default_nettype none

interface rau_out_if;
    logic               valid;
    logic               ready;
    rau_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### src/rau_mul.sv
// Iterative multiplier, four multiplier bits per cycle, product wraps at WIDTH.
// Stops early once the remaining multiplier bits are zero. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rau_mul #(
    parameter int WIDTH = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [WIDTH-1:0] i_a,
    input  wire logic [WIDTH-1:0] i_b,
    output logic                  o_done,
    output logic [WIDTH-1:0]      o_p
);

    logic             r_busy;
    logic             r_done;
    logic [WIDTH-1:0] r_acc;
    logic [WIDTH-1:0] r_a;
    logic [WIDTH-1:0] r_b;
    logic [WIDTH+3:0] w_pp;

    assign w_pp = r_a * r_b[3:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                if (r_b == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_start) begin
                r_busy <= 1'b1;
            end
        end
        if (!r_busy && i_start) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
        end else if (r_busy && r_b != '0) begin
            r_acc <= r_acc + w_pp[WIDTH-1:0];
            r_a   <= r_a << 4;
            r_b   <= r_b >> 4;
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;

endmodule

`default_nettype wire

### src/rau_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// The divisor is nonzero whenever a division is started. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rau_div #(
    parameter int WIDTH = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [WIDTH-1:0] i_num,
    input  wire logic [WIDTH-1:0] i_den,
    output logic                  o_done,
    output logic [WIDTH-1:0]      o_quo
);

    localparam int CW = $clog2(WIDTH + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_quo;
    logic [WIDTH-1:0] r_den;
    logic [WIDTH:0]   w_sh;
    logic [WIDTH:0]   w_diff;

    assign w_sh   = {r_rem, r_quo[WIDTH-1]};
    assign w_diff = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_start) begin
                r_busy <= 1'b1;
            end
        end
        if (!r_busy && i_start) begin
            r_cnt <= CW'(WIDTH);
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            r_rem <= w_diff[WIDTH] ? w_sh[WIDTH-1:0] : w_diff[WIDTH-1:0];
            r_quo <= {r_quo[WIDTH-2:0], ~w_diff[WIDTH]};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

### src/rau_gcd.sv
// Binary gcd of two nonzero unsigned values, one shift or subtract per cycle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rau_gcd #(
    parameter int WIDTH = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [WIDTH-1:0] i_u,
    input  wire logic [WIDTH-1:0] i_v,
    output logic                  o_done,
    output logic [WIDTH-1:0]      o_g
);

    localparam int KW = $clog2(WIDTH);

    logic             r_busy;
    logic             r_done;
    logic [WIDTH-1:0] r_u;
    logic [WIDTH-1:0] r_v;
    logic [KW-1:0]    r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                if (r_v == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_start) begin
                r_busy <= 1'b1;
            end
        end
        if (!r_busy && i_start) begin
            r_u <= i_u;
            r_v <= i_v;
            r_k <= '0;
        end else if (r_busy && r_v != '0) begin
            if (!r_u[0] && !r_v[0]) begin
                r_u <= r_u >> 1;
                r_v <= r_v >> 1;
                r_k <= r_k + KW'(1);
            end else if (!r_u[0]) begin
                r_u <= r_u >> 1;
            end else if (!r_v[0]) begin
                r_v <= r_v >> 1;
            end else if (r_u > r_v) begin
                r_u <= r_u - r_v;
            end else begin
                r_v <= r_v - r_u;
            end
        end
    end

    assign o_done = r_done;
    assign o_g    = r_u << r_k;

endmodule

`default_nettype wire

### src/rational_arith_unit.sv
// Top level of the rational arithmetic unit: sequencer and datapath registers.
// Depends on rau_pkg, rau_in_if, rau_out_if, rau_mul, rau_div and rau_gcd.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// The input channel carries one operation per transaction: an opcode and two
// rationals. The result channel carries exactly one result per input
// transaction, in order: a reduced numerator and denominator plus a status.
// All arithmetic is done at WIDTH bits and wraps there; the ports keep the
// full field widths, with the result numerator sign-extended.
// Latency is data dependent. Products go through one shared multiplier that
// retires four multiplier bits a cycle, the gcd takes one shift or subtract a
// cycle and the divider one quotient bit a cycle. An add needs at worst three
// products, a gcd and two divisions; pow adds up to four products for every
// bit of the exponent magnitude. Eq and unused opcodes go from decode straight
// to the done state and start no arithmetic unit.
// The unit works on one transaction at a time; input ready is high only while
// the sequencer is idle. A finished result sits in an output register, so
// the next input transaction is taken while that result waits for the sink.
// A sink that stalls with a result still pending holds the next finished
// result back inside the sequencer until the register frees up.
// Reset is synchronous and active low; it empties the output register and
// returns the sequencer to idle. The unit holds at most two items at once.
module rational_arith_unit #(
    parameter int WIDTH = rau_pkg::DEFAULT_WIDTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rau_in_if.sink    i_in,
    rau_out_if.source o_out
);

    rau_pkg::t_state r_state;
    rau_pkg::t_state n_state;

    logic [3:0]       r_kind;
    logic [WIDTH-1:0] r_an, r_ad, r_bn, r_bd;
    logic [WIDTH-1:0] r_n, r_d, r_t;
    logic [WIDTH-1:0] n_n, n_d, n_t;
    logic [1:0]       r_step, n_step;
    logic [WIDTH-1:0] r_rn, r_rd, r_pbn, r_pbd, r_e;
    logic [WIDTH-1:0] n_rn, n_rd, n_pbn, n_pbd, n_e;
    logic             r_eneg, n_eneg;
    logic [1:0]       r_pstep, n_pstep;
    logic             r_neg, n_neg;
    logic [WIDTH-1:0] r_mn, r_md, r_g;
    logic [WIDTH-1:0] n_mn, n_md, n_g;
    logic [WIDTH-1:0] r_res_num, r_res_den;
    logic [WIDTH-1:0] n_res_num, n_res_den;
    logic [1:0]       r_res_st, n_res_st;

    logic               r_ov;
    logic signed [63:0] r_o_num;
    logic [62:0]        r_o_den;
    logic [1:0]         r_o_st;

    logic             w_in_fire;
    logic             w_load_out;
    logic [63:0]      w_ad64, w_bd64;
    logic [63:0]      w_den64;
    logic signed [WIDTH-1:0] w_num_s;
    logic             w_addsub;
    logic [1:0]       w_last;
    logic             w_pcond;
    logic [WIDTH-1:0] w_mag_bn, w_mag_n, w_mag_d;

    logic             w_mul_start, w_mul_done;
    logic [WIDTH-1:0] w_mul_a, w_mul_b, w_mul_p;
    logic             w_div_start, w_div_done;
    logic [WIDTH-1:0] w_div_n, w_div_d, w_div_q;
    logic             w_gcd_start, w_gcd_done;
    logic [WIDTH-1:0] w_gcd_g;

    assign w_in_fire  = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == rau_pkg::S_IDLE);
    assign w_load_out = (r_state == rau_pkg::S_DONE) && (!r_ov || o_out.ready);

    // Input fields are cut to WIDTH bits; the denominators are zero-extended
    // first so that WIDTH = 64 still sees all of them.
    assign w_ad64 = {1'b0, i_in.data.a_den};
    assign w_bd64 = {1'b0, i_in.data.b_den};

    assign w_addsub = (r_kind == rau_pkg::OP_ADD) || (r_kind == rau_pkg::OP_SUB);
    assign w_last   = w_addsub ? 2'd2 : 2'd1;
    assign w_pcond  = r_pstep[1] ? (r_e[WIDTH-1:1] != '0) : r_e[0];
    assign w_mag_bn = r_bn[WIDTH-1] ? -r_bn : r_bn;
    assign w_mag_n  = r_n[WIDTH-1] ? -r_n : r_n;
    assign w_mag_d  = r_d[WIDTH-1] ? -r_d : r_d;

    rau_mul #(.WIDTH(WIDTH)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_p     (w_mul_p)
    );

    rau_div #(.WIDTH(WIDTH)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_n),
        .i_den   (w_div_d),
        .o_done  (w_div_done),
        .o_quo   (w_div_q)
    );

    // The gcd is started from the normalize state, so it takes the magnitudes
    // straight from the numerator and denominator registers.
    rau_gcd #(.WIDTH(WIDTH)) u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_gcd_start),
        .i_u     (w_mag_n),
        .i_v     (w_mag_d),
        .o_done  (w_gcd_done),
        .o_g     (w_gcd_g)
    );

    // Multiplier operands. Cross products are picked by opcode and step,
    // pow products by the step within one exponent bit.
    always_comb begin
        w_mul_a = r_an;
        w_mul_b = r_bd;
        if (r_state == rau_pkg::S_POW) begin
            case (r_pstep)
                2'd0:    begin w_mul_a = r_rn;  w_mul_b = r_pbn; end
                2'd1:    begin w_mul_a = r_rd;  w_mul_b = r_pbd; end
                2'd2:    begin w_mul_a = r_pbn; w_mul_b = r_pbn; end
                default: begin w_mul_a = r_pbd; w_mul_b = r_pbd; end
            endcase
        end else if (w_addsub) begin
            case (r_step)
                2'd0:    begin w_mul_a = r_an; w_mul_b = r_bd; end
                2'd1:    begin w_mul_a = r_bn; w_mul_b = r_ad; end
                default: begin w_mul_a = r_ad; w_mul_b = r_bd; end
            endcase
        end else if (r_kind == rau_pkg::OP_MUL) begin
            w_mul_a = (r_step == 2'd0) ? r_an : r_ad;
            w_mul_b = (r_step == 2'd0) ? r_bn : r_bd;
        end else begin
            w_mul_a = (r_step == 2'd0) ? r_an : r_ad;
            w_mul_b = (r_step == 2'd0) ? r_bd : r_bn;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rau_pkg::S_IDLE: begin
                if (w_in_fire) n_state = rau_pkg::S_DECODE;
            end
            rau_pkg::S_DECODE: begin
                case (r_kind) inside
                    rau_pkg::OP_ADD, rau_pkg::OP_SUB, rau_pkg::OP_MUL,
                    rau_pkg::OP_DIV, rau_pkg::OP_IDIV: n_state = rau_pkg::S_MUL_GO;
                    rau_pkg::OP_POW:                   n_state = rau_pkg::S_POW;
                    rau_pkg::OP_NEG, rau_pkg::OP_ABS:  n_state = rau_pkg::S_NORM;
                    default:                           n_state = rau_pkg::S_DONE;
                endcase
            end
            rau_pkg::S_MUL_GO: n_state = rau_pkg::S_MUL_WAIT;
            rau_pkg::S_MUL_WAIT: begin
                if (w_mul_done) begin
                    if (r_step != w_last)              n_state = rau_pkg::S_MUL_GO;
                    else if (w_addsub)                 n_state = rau_pkg::S_COMBINE;
                    else if (r_kind == rau_pkg::OP_IDIV) n_state = rau_pkg::S_IDIV;
                    else                               n_state = rau_pkg::S_NORM;
                end
            end
            rau_pkg::S_COMBINE: n_state = rau_pkg::S_NORM;
            rau_pkg::S_IDIV: begin
                n_state = (r_d == '0) ? rau_pkg::S_DONE : rau_pkg::S_IDIV_WAIT;
            end
            rau_pkg::S_IDIV_WAIT: begin
                if (w_div_done) n_state = rau_pkg::S_DONE;
            end
            rau_pkg::S_POW: begin
                if (r_e == '0)   n_state = rau_pkg::S_NORM;
                else if (w_pcond) n_state = rau_pkg::S_PMUL_WAIT;
            end
            rau_pkg::S_PMUL_WAIT: begin
                if (w_mul_done) n_state = rau_pkg::S_POW;
            end
            rau_pkg::S_NORM: begin
                if (r_d == '0 || w_mag_n == '0) n_state = rau_pkg::S_DONE;
                else                            n_state = rau_pkg::S_GCD_WAIT;
            end
            rau_pkg::S_GCD_WAIT: begin
                if (w_gcd_done) begin
                    n_state = (w_gcd_g == WIDTH'(1)) ? rau_pkg::S_FIN
                                                     : rau_pkg::S_DIVN_WAIT;
                end
            end
            rau_pkg::S_DIVN_WAIT: begin
                if (w_div_done) n_state = rau_pkg::S_DIVD_WAIT;
            end
            rau_pkg::S_DIVD_WAIT: begin
                if (w_div_done) n_state = rau_pkg::S_FIN;
            end
            rau_pkg::S_FIN: n_state = rau_pkg::S_DONE;
            rau_pkg::S_DONE: begin
                if (w_load_out) n_state = rau_pkg::S_IDLE;
            end
            default: n_state = rau_pkg::S_IDLE;
        endcase
    end

    // Datapath updates and unit starts.
    always_comb begin
        n_n = r_n;   n_d = r_d;   n_t = r_t;   n_step = r_step;
        n_rn = r_rn; n_rd = r_rd; n_pbn = r_pbn; n_pbd = r_pbd;
        n_e = r_e;   n_eneg = r_eneg; n_pstep = r_pstep;
        n_neg = r_neg; n_mn = r_mn; n_md = r_md; n_g = r_g;
        n_res_num = r_res_num; n_res_den = r_res_den; n_res_st = r_res_st;
        w_mul_start = 1'b0;
        w_div_start = 1'b0;
        w_gcd_start = 1'b0;
        w_div_n = r_mn;
        w_div_d = r_g;
        unique case (r_state)
            rau_pkg::S_DECODE: begin
                n_step  = 2'd0;
                n_rn    = WIDTH'(1);
                n_rd    = WIDTH'(1);
                n_pbn   = r_an;
                n_pbd   = r_ad;
                n_e     = w_mag_bn;
                n_eneg  = r_bn[WIDTH-1];
                n_pstep = 2'd0;
                n_d     = r_ad;
                n_n     = (r_kind == rau_pkg::OP_ABS && !r_an[WIDTH-1]) ? r_an : -r_an;
                n_res_den = WIDTH'(1);
                n_res_st  = rau_pkg::ST_OK;
                n_res_num = (r_kind == rau_pkg::OP_EQ && r_an == r_bn && r_ad == r_bd)
                            ? WIDTH'(1) : '0;
            end
            rau_pkg::S_MUL_GO: w_mul_start = 1'b1;
            rau_pkg::S_MUL_WAIT: begin
                if (w_mul_done) begin
                    if (r_step == 2'd0)        n_n = w_mul_p;
                    else if (r_step == w_last) n_d = w_mul_p;
                    else                       n_t = w_mul_p;
                    n_step = r_step + 2'd1;
                end
            end
            rau_pkg::S_COMBINE: begin
                n_n = (r_kind == rau_pkg::OP_ADD) ? r_n + r_t : r_n - r_t;
            end
            rau_pkg::S_IDIV: begin
                n_neg = r_n[WIDTH-1] ^ r_d[WIDTH-1];
                n_res_num = '0;
                n_res_den = WIDTH'(1);
                n_res_st  = rau_pkg::ST_IDIV_ZERO;
                if (r_d != '0) begin
                    w_div_start = 1'b1;
                    w_div_n = w_mag_n;
                    w_div_d = w_mag_d;
                end
            end
            rau_pkg::S_IDIV_WAIT: begin
                n_res_num = r_neg ? -w_div_q : w_div_q;
                n_res_den = WIDTH'(1);
                n_res_st  = rau_pkg::ST_OK;
            end
            rau_pkg::S_POW: begin
                if (r_e == '0) begin
                    n_n = r_eneg ? r_rd : r_rn;
                    n_d = r_eneg ? r_rn : r_rd;
                end else if (w_pcond) begin
                    w_mul_start = 1'b1;
                end else begin
                    n_pstep = r_pstep + 2'd1;
                    if (r_pstep == 2'd3) n_e = r_e >> 1;
                end
            end
            rau_pkg::S_PMUL_WAIT: begin
                if (w_mul_done) begin
                    case (r_pstep)
                        2'd0:    n_rn  = w_mul_p;
                        2'd1:    n_rd  = w_mul_p;
                        2'd2:    n_pbn = w_mul_p;
                        default: n_pbd = w_mul_p;
                    endcase
                    n_pstep = r_pstep + 2'd1;
                    if (r_pstep == 2'd3) n_e = r_e >> 1;
                end
            end
            rau_pkg::S_NORM: begin
                n_neg = r_n[WIDTH-1] ^ r_d[WIDTH-1];
                n_mn  = w_mag_n;
                n_md  = w_mag_d;
                n_res_num = '0;
                n_res_den = (r_d == '0) ? '0 : WIDTH'(1);
                n_res_st  = (r_d == '0) ? rau_pkg::ST_INVALID : rau_pkg::ST_OK;
                if (r_d != '0 && w_mag_n != '0) w_gcd_start = 1'b1;
            end
            rau_pkg::S_GCD_WAIT: begin
                if (w_gcd_done) begin
                    n_g = w_gcd_g;
                    if (w_gcd_g != WIDTH'(1)) begin
                        w_div_start = 1'b1;
                        w_div_n = r_mn;
                        w_div_d = w_gcd_g;
                    end
                end
            end
            rau_pkg::S_DIVN_WAIT: begin
                if (w_div_done) begin
                    n_mn = w_div_q;
                    w_div_start = 1'b1;
                    w_div_n = r_md;
                    w_div_d = r_g;
                end
            end
            rau_pkg::S_DIVD_WAIT: begin
                if (w_div_done) n_md = w_div_q;
            end
            rau_pkg::S_FIN: begin
                // A reduced denominator of 2^(WIDTH-1) is not a positive value.
                if (r_md[WIDTH-1]) begin
                    n_res_num = '0;
                    n_res_den = '0;
                    n_res_st  = rau_pkg::ST_INVALID;
                end else begin
                    n_res_num = r_neg ? -r_mn : r_mn;
                    n_res_den = r_md;
                    n_res_st  = rau_pkg::ST_OK;
                end
            end
            default: begin
            end
        endcase
    end

    assign w_num_s = r_res_num;
    assign w_den64 = 64'(r_res_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rau_pkg::S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out)       r_ov <= 1'b1;
            else if (o_out.ready) r_ov <= 1'b0;
        end
        if (w_in_fire) begin
            r_kind <= i_in.data.kind;
            r_an   <= i_in.data.a_num[WIDTH-1:0];
            r_ad   <= w_ad64[WIDTH-1:0];
            r_bn   <= i_in.data.b_num[WIDTH-1:0];
            r_bd   <= w_bd64[WIDTH-1:0];
        end
        r_n <= n_n;   r_d <= n_d;   r_t <= n_t;   r_step <= n_step;
        r_rn <= n_rn; r_rd <= n_rd; r_pbn <= n_pbn; r_pbd <= n_pbd;
        r_e <= n_e;   r_eneg <= n_eneg; r_pstep <= n_pstep;
        r_neg <= n_neg; r_mn <= n_mn; r_md <= n_md; r_g <= n_g;
        r_res_num <= n_res_num; r_res_den <= n_res_den; r_res_st <= n_res_st;
        if (w_load_out) begin
            r_o_num <= 64'(w_num_s);
            r_o_den <= w_den64[62:0];
            r_o_st  <= r_res_st;
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.data.res_num = r_o_num;
    assign o_out.data.res_den = r_o_den;
    assign o_out.data.status  = r_o_st;

    // A zero denominator in a pending result goes with the invalid status only.
    a_den_zero_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> ((r_o_den == '0) == (r_o_st == rau_pkg::ST_INVALID)))
        else $error("result denominator and status disagree");

    // The multiplier reports only while the sequencer waits for it.
    a_mul_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> (r_state == rau_pkg::S_MUL_WAIT ||
                        r_state == rau_pkg::S_PMUL_WAIT))
        else $error("multiplier finished outside a wait state");

    // The gcd unit reports only while the sequencer waits for it.
    a_gcd_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_gcd_done |-> (r_state == rau_pkg::S_GCD_WAIT))
        else $error("gcd finished outside its wait state");

    // Loading the output register always leaves a valid result next cycle.
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |=> (r_ov && r_state == rau_pkg::S_IDLE))
        else $error("result load did not present a result");

endmodule

`default_nettype wire

### tb/rational_arith_unit_tb.sv
// Self-checking testbench of the rational arithmetic unit: directed and random operations,
// each result checked against a predictor that does the same wrapping 64-bit arithmetic.
// Depends on rau_pkg, rau_in_if, rau_out_if and rational_arith_unit.
`timescale 1ns / 1ps

module rational_arith_unit_tb;

    localparam longint unsigned SIGN_BIT = 64'h8000_0000_0000_0000;
    localparam int CYCLE_LIMIT = 30000000;

    logic i_clk;
    logic i_rst_n;
    rau_in_if  in_ch ();
    rau_out_if out_ch ();

    rational_arith_unit #(.WIDTH(64)) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    rau_pkg::t_out_item expected_results[$];
    int        error_count;
    int        cycle_count;
    bit        idle_enable;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // The run stops here if the unit hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    function automatic longint unsigned magnitude(input longint unsigned x);
        return x[63] ? (64'd0 - x) : x;
    endfunction

    function automatic longint unsigned euclid_gcd(input longint unsigned p,
                                                   input longint unsigned q);
        longint unsigned t;
        if (p == 0 || q == 0) return 1;
        while (q != 0) begin
            t = q;
            q = p % q;
            p = t;
        end
        return p;
    endfunction

    function automatic longint unsigned wrap_power(input longint unsigned base,
                                                   input longint unsigned e);
        longint unsigned r;
        r = 1;
        while (e != 0) begin
            if (e[0]) r = r * base;
            base = base * base;
            e = e >> 1;
        end
        return r;
    endfunction

    function automatic rau_pkg::t_out_item reduce_fraction(input longint unsigned n,
                                                           input longint unsigned d);
        rau_pkg::t_out_item r;
        longint unsigned    mn;
        longint unsigned    md;
        longint unsigned    g;
        bit                 neg;
        r = '{res_num: 64'sd0, res_den: 63'd0, status: rau_pkg::ST_INVALID};
        if (d == 0) return r;
        neg = n[63] != d[63];
        mn = magnitude(n);
        md = magnitude(d);
        g = euclid_gcd(mn, md);
        mn = mn / g;
        md = md / g;
        if (mn == 0) begin
            r.res_den = 63'd1;
            r.status = rau_pkg::ST_OK;
            return r;
        end
        // A denominator of magnitude two to the 63rd cannot be represented.
        if (md >= SIGN_BIT) return r;
        r.res_num = neg ? (64'd0 - mn) : mn;
        r.res_den = md[62:0];
        r.status = rau_pkg::ST_OK;
        return r;
    endfunction

    function automatic rau_pkg::t_out_item predict_result(input rau_pkg::t_in_item it);
        longint unsigned    an;
        longint unsigned    ad;
        longint unsigned    bn;
        longint unsigned    bd;
        longint unsigned    n;
        longint unsigned    d;
        longint unsigned    q;
        longint unsigned    e;
        rau_pkg::t_out_item r;
        an = it.a_num;
        ad = {1'b0, it.a_den};
        bn = it.b_num;
        bd = {1'b0, it.b_den};
        r = '{res_num: 64'sd0, res_den: 63'd1, status: rau_pkg::ST_OK};
        case (it.kind)
            rau_pkg::OP_ADD: r = reduce_fraction(an * bd + bn * ad, ad * bd);
            rau_pkg::OP_SUB: r = reduce_fraction(an * bd - bn * ad, ad * bd);
            rau_pkg::OP_MUL: r = reduce_fraction(an * bn, ad * bd);
            rau_pkg::OP_DIV: r = reduce_fraction(an * bd, ad * bn);
            rau_pkg::OP_IDIV: begin
                n = an * bd;
                d = ad * bn;
                if (d == 0) begin
                    r.status = rau_pkg::ST_IDIV_ZERO;
                end else begin
                    q = magnitude(n) / magnitude(d);
                    r.res_num = (n[63] != d[63]) ? (64'd0 - q) : q;
                end
            end
            rau_pkg::OP_POW: begin
                e = magnitude(bn);
                n = wrap_power(an, e);
                d = wrap_power(ad, e);
                r = bn[63] ? reduce_fraction(d, n) : reduce_fraction(n, d);
            end
            rau_pkg::OP_NEG: r = reduce_fraction(64'd0 - an, ad);
            rau_pkg::OP_ABS: r = reduce_fraction(an[63] ? 64'd0 - an : an, ad);
            rau_pkg::OP_EQ:  r.res_num = (an == bn && ad == bd) ? 64'sd1 : 64'sd0;
            default: ;
        endcase
        return r;
    endfunction

    function automatic bit roll_idle();
        return idle_enable && ($urandom_range(99) < 6);
    endfunction

    // Sends one operation and queues its expected result once it is accepted.
    // Valid stays high on return so that the next transaction can follow at once.
    task automatic send_operation(input logic [3:0] kind, input longint an,
                                  input longint unsigned ad, input longint bn,
                                  input longint unsigned bd);
        rau_pkg::t_in_item it;
        it = '{kind: kind, a_num: an, a_den: ad[62:0], b_num: bn, b_den: bd[62:0]};
        while (roll_idle()) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        expected_results.insert(expected_results.size(), predict_result(it));
        @(negedge i_clk);
    endtask

    // Result side: random back-pressure, each transaction checked in order.
    always @(negedge i_clk) begin
        out_ch.ready <= !roll_idle();
    end

    always @(posedge i_clk) begin
        rau_pkg::t_out_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with no operation pending");
            end else begin
                want = expected_results.pop_front();
                if (out_ch.data.res_num !== want.res_num)
                    report_mismatch($sformatf("res_num %0d, want %0d",
                                    out_ch.data.res_num, want.res_num));
                if (out_ch.data.res_den !== want.res_den)
                    report_mismatch($sformatf("res_den %0d, want %0d",
                                    out_ch.data.res_den, want.res_den));
                if (out_ch.data.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                    out_ch.data.status, want.status));
            end
        end
    end

    function automatic longint unsigned pick_value();
        case ($urandom_range(5))
            0: return $urandom_range(9);
            1: return {$urandom, $urandom};
            2: return $urandom_range(1000);
            3: return {$urandom, $urandom} >> $urandom_range(63);
            4: return 64'h8000_0000_0000_0000 + $urandom_range(2);
            default: return 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(3);
        endcase
    endfunction

    function automatic longint pick_numerator();
        longint unsigned v;
        v = pick_value();
        return $urandom_range(1) ? -longint'(v) : longint'(v);
    endfunction

    function automatic longint unsigned pick_denominator();
        longint unsigned v;
        v = pick_value() & 64'h7FFF_FFFF_FFFF_FFFF;
        // Denominators are mostly positive; a zero slips through now and then.
        return (v == 0 && $urandom_range(3) != 0) ? 1 : v;
    endfunction

    task automatic test_extremes();
        longint maxp;
        longint minn;
        maxp = 64'sh7FFF_FFFF_FFFF_FFFF;
        minn = 64'sh8000_0000_0000_0000;
        send_operation(rau_pkg::OP_ADD, 1, 2, 1, 3);
        send_operation(rau_pkg::OP_SUB, 1, 2, 1, 2);
        send_operation(rau_pkg::OP_MUL, maxp, 1, maxp, 1);
        send_operation(rau_pkg::OP_DIV, 3, 4, 0, 1);
        send_operation(rau_pkg::OP_DIV, minn, 1, -1, 1);
        send_operation(rau_pkg::OP_IDIV, 7, 1, -2, 1);
        send_operation(rau_pkg::OP_IDIV, 5, 1, 0, 1);
        send_operation(rau_pkg::OP_IDIV, minn, 1, -1, 1);
        send_operation(rau_pkg::OP_POW, 2, 3, 10, 1);
        send_operation(rau_pkg::OP_POW, -2, 3, -3, 1);
        send_operation(rau_pkg::OP_POW, 0, 1, -2, 1);
        send_operation(rau_pkg::OP_POW, 3, 1, minn, 1);
        send_operation(rau_pkg::OP_POW, 5, 7, 0, 1);
        send_operation(rau_pkg::OP_NEG, minn, 1, 0, 1);
        send_operation(rau_pkg::OP_ABS, -6, 4, 0, 1);
        send_operation(rau_pkg::OP_ABS, maxp, 64'h7FFF_FFFF_FFFF_FFFF, 0, 1);
        send_operation(rau_pkg::OP_EQ, minn, 5, minn, 5);
        send_operation(rau_pkg::OP_EQ, 1, 2, 1, 3);
        send_operation(rau_pkg::OP_ADD, 1, 0, 1, 1);
        send_operation(rau_pkg::OP_MUL, 1, 64'h4000_0000_0000_0000, 1, 2);
        send_operation(rau_pkg::OP_MUL, 0, 5, maxp, 9);
        send_operation(4'd9, 1, 1, 1, 1);
        send_operation(4'd15, -1, 3, 2, 7);
    endtask

    task automatic test_random_operations(input int count);
        logic [3:0]      kind;
        longint          an;
        longint          bn;
        longint unsigned ad;
        longint unsigned bd;
        for (int i = 0; i < count; i++) begin
            // A stretch in the middle runs with no idling on either side.
            idle_enable = !(i >= count / 2 && i < count / 2 + 150);
            kind = ($urandom_range(19) == 0) ? 4'($urandom_range(15)) :
                                               4'($urandom_range(8));
            an = pick_numerator();
            ad = pick_denominator();
            bn = pick_numerator();
            bd = ($urandom_range(2) == 0) ? 1 : pick_denominator();
            // Pow mostly gets small exponents to keep the run short.
            if (kind == rau_pkg::OP_POW && $urandom_range(7) != 0)
                bn = longint'($urandom_range(40)) - 20;
            if (kind == rau_pkg::OP_EQ && $urandom_range(1)) begin
                bn = an;
                bd = ad;
            end
            send_operation(kind, an, ad, bn, bd);
        end
        idle_enable = 1'b1;
    endtask

    initial begin
        int guard;
        error_count = 0;
        cycle_count = 0;
        idle_enable = 1'b1;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_extremes();
        test_random_operations(1230);
        in_ch.valid <= 1'b0;

        guard = 0;
        while (expected_results.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (400) @(posedge i_clk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

### sim.f
src/rau_pkg.sv
src/rau_in_if.sv
src/rau_out_if.sv
src/rau_mul.sv
src/rau_div.sv
src/rau_gcd.sv
src/rational_arith_unit.sv
tb/rational_arith_unit_tb.sv
